// ===== src/vspi_pkg.sv =====
// Shared types and constants for the velocity slew and pose integrator.
package vspi_pkg;

  // Sine phase resolution: 2^SINE_INDEX_BITS phase points per turn
  localparam int SINE_INDEX_BITS = 10;
  localparam logic [15:0] PHASE_MASK = 16'(17'h0FFFF << (16 - SINE_INDEX_BITS));
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // Quarter-wave sine polynomial coefficients (Q15)
  localparam logic [16:0] SIN_ONE = 17'd32768;
  localparam logic [17:0] SIN_C1 = 18'd2320;
  localparam logic [17:0] SIN_C2 = 18'd21024;
  localparam logic [17:0] SIN_C3 = 18'd51472;

  // Register map (word index)
  localparam logic [1:0] REG_MAX_STEP_LINEAR  = 2'd0;
  localparam logic [1:0] REG_MAX_STEP_ANGULAR = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD      = 2'd2;

  // Register reset values
  localparam logic [14:0] RST_MAX_STEP_LINEAR  = 15'd123;
  localparam logic [19:0] RST_MAX_STEP_ANGULAR = 20'd4096;
  localparam logic [15:0] RST_TICK_PERIOD      = 16'd655;

  // Multiplier sequence: each step issues one product and retires the previous one
  localparam logic [3:0] STEP_SQ_S   = 4'd0;   // us * us
  localparam logic [3:0] STEP_SQ_C   = 4'd1;   // uc * uc
  localparam logic [3:0] STEP_C1_S   = 4'd2;   // u2s * c1
  localparam logic [3:0] STEP_C1_C   = 4'd3;   // u2c * c1
  localparam logic [3:0] STEP_C2_S   = 4'd4;   // u2s * (c2 - ts)
  localparam logic [3:0] STEP_C2_C   = 4'd5;   // u2c * (c2 - tc)
  localparam logic [3:0] STEP_C3_S   = 4'd6;   // us * (c3 - ts)
  localparam logic [3:0] STEP_C3_C   = 4'd7;   // uc * (c3 - tc)
  localparam logic [3:0] STEP_VX_SIN = 4'd8;   // vx * sin
  localparam logic [3:0] STEP_VY_COS = 4'd9;   // vy * cos
  localparam logic [3:0] STEP_VX_COS = 4'd10;  // vx * cos
  localparam logic [3:0] STEP_VY_SIN = 4'd11;  // vy * sin
  localparam logic [3:0] STEP_DY     = 4'd12;  // world vy * period
  localparam logic [3:0] STEP_DX     = 4'd13;  // world vx * period
  localparam logic [3:0] STEP_DH     = 4'd14;  // omega * period
  localparam logic [3:0] STEP_LAST   = 4'd15;  // retire heading only

  // Configuration register set
  typedef struct packed {
    logic [14:0] max_step_linear;
    logic [19:0] max_step_angular;
    logic [15:0] tick_period;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_target;
    logic       slew;
    logic       mul_en;
    logic [3:0] step;
    logic       load_out;
  } cmd_t;

endpackage

// ===== src/vspi_cfg.sv =====
// APB-style configuration register bank.
module vspi_cfg import vspi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_step_linear  <= RST_MAX_STEP_LINEAR;
      cfg_r.max_step_angular <= RST_MAX_STEP_ANGULAR;
      cfg_r.tick_period      <= RST_TICK_PERIOD;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MAX_STEP_LINEAR:  cfg_r.max_step_linear  <= pwdata[14:0];
        REG_MAX_STEP_ANGULAR: cfg_r.max_step_angular <= pwdata[19:0];
        REG_TICK_PERIOD:      cfg_r.tick_period      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      REG_MAX_STEP_LINEAR:  prdata = {17'd0, cfg_r.max_step_linear};
      REG_MAX_STEP_ANGULAR: prdata = {12'd0, cfg_r.max_step_angular};
      REG_TICK_PERIOD:      prdata = {16'd0, cfg_r.tick_period};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/vspi_ctrl.sv =====
// Sequencer: request handshake, slew cycle, multiplier step count, result handoff.
module vspi_ctrl import vspi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SLEW, S_MUL, S_DONE} state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    cmd.load_target = 1'b0;
    cmd.slew        = 1'b0;
    cmd.mul_en      = 1'b0;
    cmd.step        = step_r;
    cmd.load_out    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_target = 1'b1;
          state_nxt       = S_SLEW;
        end
      end
      S_SLEW: begin
        cmd.slew  = 1'b1;
        step_nxt  = STEP_SQ_S;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        step_nxt   = step_r + 4'd1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand off once the output register is free or draining
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_SQ_S;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/vspi_dp.sv =====
// Datapath: slew limiters, shared multiplier, sine polynomial, pose integration.
module vspi_dp import vspi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic               in_new_target,
  input  logic signed [15:0] in_target_vx,
  input  logic signed [15:0] in_target_vy,
  input  logic signed [20:0] in_target_omega,
  output logic signed [15:0] out_smooth_vx,
  output logic signed [15:0] out_smooth_vy,
  output logic signed [20:0] out_smooth_omega,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic        [15:0] out_pose_heading
);

  // Architectural state
  logic signed [15:0] held_vx_r, held_vy_r, prev_vx_r, prev_vy_r;
  logic signed [20:0] held_omega_r, prev_omega_r;
  logic signed [31:0] world_x_r, world_y_r;
  logic        [15:0] heading_r;

  // Per-tick working registers
  logic        [16:0] us_r, uc_r, u2s_r, u2c_r;
  logic        [15:0] ts_r, tc_r;
  logic               neg_s_r, neg_c_r;
  logic signed [16:0] sn_r, cs_r;
  logic signed [33:0] accx_r, accy_r;
  logic signed [52:0] prod_r;

  // Result register
  logic signed [15:0] o_vx_r, o_vy_r;
  logic signed [20:0] o_omega_r;
  logic signed [31:0] o_x_r, o_y_r;
  logic        [15:0] o_head_r;

  logic signed [22:0] slew_vx, slew_vy, slew_om;
  logic        [15:0] ph_s, ph_c;
  logic        [16:0] u_s, u_c;
  logic signed [34:0] opa;
  logic signed [17:0] opb, dt_b;
  logic signed [52:0] rnd_pos, rnd_head;
  logic signed [25:0] pos_inc;
  logic signed [31:0] sat_x, sat_y;
  logic        [15:0] mag;
  logic signed [16:0] mag_s;

  // Move cur toward tgt by at most lim
  function automatic logic signed [22:0] slew_fn(input logic signed [22:0] cur,
                                                 input logic signed [22:0] tgt,
                                                 input logic signed [22:0] lim);
    logic signed [22:0] d;
    d = tgt - cur;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return cur + d;
  endfunction

  // Saturating add of a position increment
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                 input logic signed [25:0] inc);
    logic signed [33:0] s;
    s = 34'(w) + 34'(inc);
    if (s > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -34'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  // Slew limits
  assign slew_vx = slew_fn(23'(prev_vx_r), 23'(held_vx_r),
                           $signed({8'd0, cfg.max_step_linear}));
  assign slew_vy = slew_fn(23'(prev_vy_r), 23'(held_vy_r),
                           $signed({8'd0, cfg.max_step_linear}));
  assign slew_om = slew_fn(23'(prev_omega_r), 23'(held_omega_r),
                           $signed({3'd0, cfg.max_step_angular}));

  // Phase folding into the first quadrant
  assign ph_s = heading_r & PHASE_MASK;
  assign ph_c = ph_s + QUARTER_TURN;
  assign u_s  = ph_s[14] ? SIN_ONE - {2'd0, ph_s[13:0], 1'b0} : {2'd0, ph_s[13:0], 1'b0};
  assign u_c  = ph_c[14] ? SIN_ONE - {2'd0, ph_c[13:0], 1'b0} : {2'd0, ph_c[13:0], 1'b0};

  assign dt_b = $signed({2'd0, cfg.tick_period});

  // Multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.step)
      STEP_SQ_S:   begin opa = $signed({18'd0, us_r});  opb = $signed({1'b0, us_r}); end
      STEP_SQ_C:   begin opa = $signed({18'd0, uc_r});  opb = $signed({1'b0, uc_r}); end
      STEP_C1_S:   begin opa = $signed({18'd0, u2s_r}); opb = SIN_C1; end
      STEP_C1_C:   begin opa = $signed({18'd0, u2c_r}); opb = SIN_C1; end
      STEP_C2_S:   begin opa = $signed({18'd0, u2s_r}); opb = SIN_C2 - {2'd0, ts_r}; end
      STEP_C2_C:   begin opa = $signed({18'd0, u2c_r}); opb = SIN_C2 - {2'd0, tc_r}; end
      STEP_C3_S:   begin opa = $signed({18'd0, us_r});  opb = SIN_C3 - {2'd0, ts_r}; end
      STEP_C3_C:   begin opa = $signed({18'd0, uc_r});  opb = SIN_C3 - {2'd0, tc_r}; end
      STEP_VX_SIN: begin opa = 35'(prev_vx_r); opb = 18'(sn_r); end
      STEP_VY_COS: begin opa = 35'(prev_vy_r); opb = 18'(cs_r); end
      STEP_VX_COS: begin opa = 35'(prev_vx_r); opb = 18'(cs_r); end
      STEP_VY_SIN: begin opa = 35'(prev_vy_r); opb = 18'(sn_r); end
      STEP_DY:     begin opa = 35'(accy_r); opb = dt_b; end
      STEP_DX:     begin opa = 35'(accx_r); opb = dt_b; end
      STEP_DH:     begin opa = 35'(prev_omega_r); opb = dt_b; end
      default: ;
    endcase
  end

  // Product rounding and retire helpers
  assign rnd_pos  = prod_r + 53'sd67108864;
  assign pos_inc  = rnd_pos[52:27];
  assign rnd_head = prod_r + 53'sd32768;
  assign sat_x    = sat_add(world_x_r, pos_inc);
  assign sat_y    = sat_add(world_y_r, pos_inc);
  assign mag      = prod_r[30:15];
  assign mag_s    = $signed({prod_r[31], mag});

  // Target hold, slew and per-step retire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vx_r    <= '0;
      held_vy_r    <= '0;
      held_omega_r <= '0;
      prev_vx_r    <= '0;
      prev_vy_r    <= '0;
      prev_omega_r <= '0;
      world_x_r    <= '0;
      world_y_r    <= '0;
      heading_r    <= '0;
    end else begin
      if (cmd.load_target && in_new_target) begin
        held_vx_r    <= in_target_vx;
        held_vy_r    <= in_target_vy;
        held_omega_r <= in_target_omega;
      end
      if (cmd.slew) begin
        prev_vx_r    <= slew_vx[15:0];
        prev_vy_r    <= slew_vy[15:0];
        prev_omega_r <= slew_om[20:0];
      end
      if (cmd.mul_en) begin
        case (cmd.step)
          STEP_DX:   world_y_r <= sat_y;
          STEP_DH:   world_x_r <= sat_x;
          STEP_LAST: heading_r <= heading_r + rnd_head[31:16];
          default: ;
        endcase
      end
    end
  end

  // Working registers: quadrant setup, multiplier, retire of each product
  always_ff @(posedge clk) begin
    if (cmd.slew) begin
      us_r    <= u_s;
      uc_r    <= u_c;
      neg_s_r <= ph_s[15];
      neg_c_r <= ph_c[15];
    end
    if (cmd.mul_en) begin
      prod_r <= opa * opb;
      case (cmd.step)
        STEP_SQ_C:   u2s_r  <= prod_r[31:15];
        STEP_C1_S:   u2c_r  <= prod_r[31:15];
        STEP_C1_C:   ts_r   <= prod_r[30:15];
        STEP_C2_S:   tc_r   <= prod_r[30:15];
        STEP_C2_C:   ts_r   <= prod_r[30:15];
        STEP_C3_S:   tc_r   <= prod_r[30:15];
        STEP_C3_C:   sn_r   <= neg_s_r ? -mag_s : mag_s;
        STEP_VX_SIN: cs_r   <= neg_c_r ? -mag_s : mag_s;
        STEP_VY_COS: accy_r <= prod_r[33:0];
        STEP_VX_COS: accy_r <= accy_r + prod_r[33:0];
        STEP_VY_SIN: accx_r <= prod_r[33:0];
        STEP_DY:     accx_r <= accx_r - prod_r[33:0];
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_vx_r    <= prev_vx_r;
      o_vy_r    <= prev_vy_r;
      o_omega_r <= prev_omega_r;
      o_x_r     <= world_x_r;
      o_y_r     <= world_y_r;
      o_head_r  <= heading_r;
    end
  end

  assign out_smooth_vx    = o_vx_r;
  assign out_smooth_vy    = o_vy_r;
  assign out_smooth_omega = o_omega_r;
  assign out_pose_x       = o_x_r;
  assign out_pose_y       = o_y_r;
  assign out_pose_heading = o_head_r;

endmodule

// ===== src/velocity_slew_and_pose_integrator_unit.sv =====
// Top level of the velocity slew limiter and dead-reckoning pose integrator.
//
// Each accepted request optionally loads a new body-frame velocity target, steps
// the smoothed velocity toward it within the programmed per-tick limits, rotates
// it into the world frame by the previous heading and integrates it over the tick
// period into the pose setpoint. One result per request. A request is taken when
// the block is idle; the next request waits until the result is handed to the
// output register. The pace is set by the single shared 35x18 multiplier, which
// runs sixteen steps in sequence: eight products for the sine and cosine
// polynomials, four for the rotation, three for the position and heading
// increments, and a last step that only retires the heading increment. A result
// waits in an output register, so the next request can run while the output is
// stalled; its handoff then waits until that register is free or draining.
// Registers: 0x0 max step linear, 0x4 max step angular, 0x8 tick period.
module velocity_slew_and_pose_integrator_unit import vspi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_new_target,
  input  logic signed [15:0] in_target_vx,
  input  logic signed [15:0] in_target_vy,
  input  logic signed [20:0] in_target_omega,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_smooth_vx,
  output logic signed [15:0] out_smooth_vy,
  output logic signed [20:0] out_smooth_omega,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic        [15:0] out_pose_heading
);

  cfg_t cfg;
  cmd_t cmd;

  vspi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vspi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  vspi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_new_target    (in_new_target),
    .in_target_vx     (in_target_vx),
    .in_target_vy     (in_target_vy),
    .in_target_omega  (in_target_omega),
    .out_smooth_vx    (out_smooth_vx),
    .out_smooth_vy    (out_smooth_vy),
    .out_smooth_omega (out_smooth_omega),
    .out_pose_x       (out_pose_x),
    .out_pose_y       (out_pose_y),
    .out_pose_heading (out_pose_heading)
  );

endmodule
